// ===== hdl/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W = 6;
    localparam int CHAR_W = 7;

    // Quotient bits resolved per cycle by the shared divider.
    localparam int DIV_STEP = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_MINUS,
        S_FETCH,
        S_EMIT
    } itoa_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE) begin
            c = CHAR_W'(d - DIGIT_TEN) + CH_A;
        end
        else begin
            c = CHAR_W'(d) + CH_ZERO;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_radix_ascii_top.sv =====
// Integer to ASCII text converter for radix 2 to 36.
// Input channel (in_valid/in_ready): value_bits, signed_mode and radix. A radix
// below 2 is treated as 2 and one above 36 as 36. In signed mode a negative
// value prints a leading '-' and then its magnitude.
// Output channel (out_valid/out_ready): one ASCII character per transfer,
// most significant character first; last_char marks the final one.
// Digits come from a shared divider that resolves 8 quotient bits per cycle.
// Digits are kept in a small store and then read back in reverse, each
// character passing through a fetch state and an emit state; a minus sign
// takes a state of its own.
// in_ready is high only while no item is in progress; the next item is
// accepted once the final character sits in the output register.
// A stalled receiver holds the character in the output register and pauses
// the read-back; nothing is dropped. Reset clears the sequencer, the divider
// control and the output valid flag.
`default_nettype none

module integer_to_radix_ascii_top
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] value_bits,
    input  wire logic                   signed_mode,
    input  wire logic [RADIX_W-1:0]     radix,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CHAR_W-1:0]           char_out,
    output logic                        last_char
);

    localparam int PTR_W = $clog2(VALUE_WIDTH);

    itoa_state_t state_reg, state_next;

    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic                   minus_reg, minus_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic [RADIX_W-1:0]     digit_store [VALUE_WIDTH];
    logic [RADIX_W-1:0]     rd_data_reg;
    logic                   store_we;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [RADIX_W-1:0]     div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [RADIX_W-1:0]     div_rem;

    logic                   slot_free;
    logic                   in_negative;
    logic [RADIX_W-1:0]     radix_sat;

    itoa_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_negative = signed_mode && value_bits[VALUE_WIDTH-1];

    always_comb
    begin
        if (radix < RADIX_MIN)
        begin
            radix_sat = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            radix_sat = RADIX_MAX;
        end
        else
        begin
            radix_sat = radix;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        radix_next = radix_reg;
        minus_next = minus_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next = char_reg;
        last_next = last_reg;
        store_we = 1'b0;
        div_start = 1'b0;
        div_dividend = div_quot;
        div_divisor = radix_reg;
        in_ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                div_divisor = radix_sat;
                div_dividend = in_negative ? (~value_bits + 1'b1) : value_bits;
                if (in_valid)
                begin
                    div_start = 1'b1;
                    radix_next = radix_sat;
                    minus_next = in_negative;
                    ptr_next = '0;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    store_we = 1'b1;
                    if (div_quot != '0)
                    begin
                        div_start = 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else if (minus_reg)
                    begin
                        state_next = S_MINUS;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_MINUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = CH_MINUS;
                    last_next = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = digit_char(rd_data_reg);
                    last_next = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            minus_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            minus_reg <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Digits are written least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[ptr_reg] <= div_rem;
        end
        rd_data_reg <= digit_store[ptr_reg];
    end

    assign out_valid = out_valid_reg;
    assign char_out = char_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (div_rem < radix_reg))
        else $error("digit remainder not below radix");

    a_radix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX))
        else $error("working radix out of range");

    a_done_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && ptr_reg == '0) |=>
            (state_reg == S_IDLE && out_valid && last_char))
        else $error("final character did not close the item");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MINUS && slot_free) |=> (char_out == CH_MINUS && !last_char))
        else $error("minus sign marked as final character");
`endif

endmodule

`default_nettype wire

// ===== hdl/itoa_div.sv =====
`default_nettype none

module itoa_div
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [RADIX_W-1:0]     divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [RADIX_W-1:0]          remainder
);

    localparam int STEPS = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W = STEPS * DIV_STEP;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0]      work_reg, work_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    divisor_reg, divisor_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [RADIX_W:0]      trial;
    logic [RADIX_W-1:0]    rem_step;
    logic [DIV_STEP-1:0]   qbits;

    // Restoring division, DIV_STEP dividend bits per cycle.  The dividend
    // shifts out at the top while quotient bits shift in at the bottom.
    always_comb
    begin
        trial = '0;
        rem_step = rem_reg;
        qbits = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_step, work_reg[PAD_W-1-i]};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial = trial - {1'b0, divisor_reg};
                qbits[DIV_STEP-1-i] = 1'b1;
            end
            rem_step = trial[RADIX_W-1:0];
        end
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = PAD_W'(dividend);
            rem_next = '0;
            divisor_next = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = (work_reg << DIV_STEP) | PAD_W'(qbits);
            rem_next = rem_step;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done = done_reg;
    assign quotient = work_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== tb/sv/integer_to_radix_ascii_top_test.sv =====
`timescale 1ns / 100ps

module integer_to_radix_ascii_top_test;
    import itoa_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [RADIX_W-1:0] RADIX_TOP = {RADIX_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    // Builds the expected character stream of each accepted number and checks
    // every character transfer against it in order.
    class text_scoreboard;
        text_char_t pending_chars[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        function void note_number(logic [VW-1:0] value, logic is_signed,
                                  logic [RADIX_W-1:0] base_in);
            logic [RADIX_W-1:0] base;
            logic [VW-1:0]      magnitude;
            logic [RADIX_W-1:0] digits[$];
            logic [RADIX_W-1:0] d;
            text_char_t         t;
            base = base_in;
            if (base < RADIX_MIN)
            begin
                base = RADIX_MIN;
            end
            if (base > RADIX_MAX)
            begin
                base = RADIX_MAX;
            end
            magnitude = value;
            if (is_signed && value[VW-1])
            begin
                // The most negative value wraps to itself, which reads as 2^31 unsigned.
                magnitude = '0 - value;
                t.ch = CH_MINUS;
                t.last = 1'b0;
                pending_chars.push_back(t);
            end
            do
            begin
                digits.push_front(RADIX_W'(magnitude % VW'(base)));
                magnitude = magnitude / VW'(base);
            end
            while (magnitude != '0);
            for (int i = 0; i < digits.size(); i++)
            begin
                d = digits[i];
                t.ch = (d < DIGIT_TEN) ? CH_ZERO + CHAR_W'(d) : CH_A + CHAR_W'(d - DIGIT_TEN);
                t.last = (i == digits.size() - 1);
                pending_chars.push_back(t);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            text_char_t t;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: char_out %h, last_char %b", ch, last);
                failures++;
                return;
            end
            t = pending_chars.pop_front();
            if (ch !== t.ch)
            begin
                $error("char_out: expected %h, got %h", t.ch, ch);
                failures++;
            end
            if (last !== t.last)
            begin
                $error("last_char: expected %b, got %b", t.last, last);
                failures++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VW-1:0]      value_bits = '0;
    logic               signed_mode = 1'b0;
    logic [RADIX_W-1:0] radix = RADIX_MIN;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  char_out;
    logic               last_char;

    int             send_idle_pct = 9;
    int             recv_idle_pct = 82;
    int unsigned    cycle_count = 0;
    text_scoreboard sb;

    integer_to_radix_ascii_top #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value_bits(value_bits),
        .signed_mode(signed_mode),
        .radix(radix),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_out(char_out),
        .last_char(last_char)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_number(value_bits, signed_mode, radix);
            end
            if (out_valid && out_ready)
            begin
                sb.check_char(char_out, last_char);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_number(input logic [VW-1:0] v, input logic s,
                               input logic [RADIX_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value_bits <= v;
        signed_mode <= s;
        radix <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Holds the input off until every outstanding character has been transferred.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending_chars.size() != 0);
    endtask

    task automatic send_random_number();
        logic [VW-1:0]      v;
        logic [RADIX_W-1:0] r;
        case ($urandom_range(0, 5))
            0: v = VW'($urandom);
            1: v = VW'($urandom_range(0, 40));
            2: v = '0 - VW'($urandom_range(1, 40));
            3: v = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
            4: v = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
            default: v = VW'($urandom >> $urandom_range(0, VW - 1));
        endcase
        if ($urandom_range(0, 99) < 85)
        begin
            r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        end
        else
        begin
            r = RADIX_W'($urandom_range(0, RADIX_TOP));
        end
        send_number(v, 1'($urandom_range(0, 1)), r);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number('0, 1'b0, 6'd10);
        send_number('0, 1'b1, RADIX_MIN);
        send_number('1, 1'b0, RADIX_MIN);
        send_number('1, 1'b1, 6'd10);
        send_number('1, 1'b0, RADIX_MAX);
        send_number(32'h8000_0000, 1'b1, RADIX_MIN);
        send_number(32'h8000_0000, 1'b1, 6'd10);
        send_number(32'h8000_0000, 1'b0, 6'd16);
        send_number(32'h7FFF_FFFF, 1'b1, RADIX_MAX);
        send_number(32'h7FFF_FFFF, 1'b0, 6'd8);
        send_number(32'hDEAD_BEEF, 1'b0, 6'd16);
        send_number(32'hDEAD_BEEF, 1'b1, 6'd16);
        send_number(32'd9, 1'b0, 6'd10);
        send_number(32'd10, 1'b0, 6'd10);
        send_number(32'd10, 1'b0, 6'd11);
        send_number(32'd34, 1'b0, 6'd35);
        send_number(32'd35, 1'b1, RADIX_MAX);
        send_number(32'd12345, 1'b1, 6'd8);
        // A radix below two behaves as binary, one above thirty-six as base 36.
        send_number(32'd5, 1'b0, 6'd0);
        send_number(32'd6, 1'b1, 6'd1);
        send_number(32'd71, 1'b0, 6'd37);
        send_number(32'hFFFF_FF00, 1'b1, RADIX_TOP);
        send_number(32'hFFFF_FF00, 1'b0, RADIX_TOP);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    drain_results();
                end
                send_random_number();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending_chars.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
